// ===== hdl/jet_pkg.sv =====
// Shared constants for the Julia escape-time block: word and product widths,
// escape thresholds and configuration register indexes.
// No dependencies; imported by julia_escape_time.
package jet_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;

    // Double-width exact products, and one more bit for their sum or difference.
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    // Width of a rescaled component before the escape test narrows it.
    localparam int NEXT_BITS = PROD_BITS - FRAC_BITS + 3;

    // Stages in the iteration ring, and the width of the in-order tag.
    localparam int RING_DEPTH = 4;
    localparam int TAG_BITS   = $clog2(RING_DEPTH);

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_BITS = ((2 * WORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((COUNT_BITS + 7) / 8) * 8;

    // Escape thresholds: |component| > 2 and |z|^2 > 4.
    localparam logic signed [NEXT_BITS-1:0] TWO_POS = NEXT_BITS'(1) << (FRAC_BITS + 1);
    localparam logic signed [NEXT_BITS-1:0] TWO_NEG = -TWO_POS;
    localparam logic signed [SUM_BITS-1:0]  MAG_LIMIT = SUM_BITS'(1) << (2 * FRAC_BITS + 2);

    // Configuration registers.
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CONST_REAL = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CONST_IMAG = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ITER_LIMIT = 2'd2;

    localparam logic [COUNT_BITS-1:0] ITER_LIMIT_RESET = COUNT_BITS'(100);

endpackage

// ===== hdl/julia_escape_time.sv =====
// Julia-set escape-time counter: iterates z = z*z + c on a four-stage ring.
// Depends on jet_pkg for widths, thresholds and register indexes.
//
//  Channel   Direction  Payload                                   Transfer when
//  s_        in         tdata: start_real, start_imag             s_tvalid && s_tready
//  m_        out        tdata: escape_count                       m_tvalid && m_tready
//  cfg_      in         index cfg_addr, value cfg_wdata           cfg_wr_en
//
// One iteration is one trip around the ring of RING_DEPTH (4) stages: multiply,
// add/compare, rescale, decide. Up to four points share the ring, one per stage
// slot. Results leave strictly in input order; finished points keep circulating
// until their turn. Reset is synchronous and active low; it empties the ring and
// loads c = 0 and an iteration limit of 100. A stalled output only holds the
// output register; the ring keeps turning and refuses new points while its entry
// slot is taken.
module julia_escape_time (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0: start_real, start_imag
    input  logic [jet_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: escape_count
    output logic [jet_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [jet_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [jet_pkg::WORD_BITS-1:0]     cfg_wdata
);
    import jet_pkg::*;

    // Configuration
    logic signed [WORD_BITS-1:0]  const_real_reg;
    logic signed [WORD_BITS-1:0]  const_imag_reg;
    logic        [COUNT_BITS-1:0] iter_limit_reg;

    // Stage A: current z
    logic                         a_valid_reg, a_valid_next;
    logic                         a_done_reg, a_done_next;
    logic        [TAG_BITS-1:0]   a_tag_reg, a_tag_next;
    logic        [COUNT_BITS-1:0] a_iter_reg, a_iter_next;
    logic        [COUNT_BITS-1:0] a_result_reg, a_result_next;
    logic signed [WORD_BITS-1:0]  a_re_reg, a_re_next;
    logic signed [WORD_BITS-1:0]  a_im_reg, a_im_next;

    // Stage B: exact products
    logic                         b_valid_reg;
    logic                         b_done_reg;
    logic        [TAG_BITS-1:0]   b_tag_reg;
    logic        [COUNT_BITS-1:0] b_iter_reg;
    logic        [COUNT_BITS-1:0] b_result_reg;
    logic signed [PROD_BITS-1:0]  b_rr_reg, b_rr_next;
    logic signed [PROD_BITS-1:0]  b_ii_reg, b_ii_next;
    logic signed [PROD_BITS-1:0]  b_ri_reg, b_ri_next;

    // Stage C: magnitude test and difference of squares
    logic                         c_valid_reg;
    logic                         c_done_reg;
    logic        [TAG_BITS-1:0]   c_tag_reg;
    logic        [COUNT_BITS-1:0] c_iter_reg;
    logic        [COUNT_BITS-1:0] c_result_reg;
    logic                         c_mag_esc_reg, c_mag_esc_next;
    logic signed [SUM_BITS-1:0]   c_diff_reg, c_diff_next;
    logic signed [PROD_BITS-1:0]  c_ri_reg;
    logic signed [SUM_BITS-1:0]   mag_sum;

    // Stage D: rescaled next z
    logic                         d_valid_reg;
    logic                         d_done_reg;
    logic        [TAG_BITS-1:0]   d_tag_reg;
    logic        [COUNT_BITS-1:0] d_iter_reg;
    logic        [COUNT_BITS-1:0] d_result_reg;
    logic                         d_mag_esc_reg;
    logic signed [NEXT_BITS-1:0]  d_nr_reg, d_nr_next;
    logic signed [NEXT_BITS-1:0]  d_ni_reg, d_ni_next;

    // Ordering and output
    logic [TAG_BITS-1:0]   in_seq_reg, in_seq_next;
    logic [TAG_BITS-1:0]   out_seq_reg, out_seq_next;
    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_BITS-1:0] m_count_reg, m_count_next;

    logic                  finished;
    logic [COUNT_BITS-1:0] fin_result;
    logic                  comp_esc;
    logic                  out_free;
    logic                  exit_now;
    logic                  accept;

    // ---------------------------------------------------------------- datapath
    assign b_rr_next = a_re_reg * a_re_reg;
    assign b_ii_next = a_im_reg * a_im_reg;
    assign b_ri_next = a_re_reg * a_im_reg;

    assign mag_sum        = SUM_BITS'(b_rr_reg) + SUM_BITS'(b_ii_reg);
    assign c_mag_esc_next = mag_sum > MAG_LIMIT;
    assign c_diff_next    = SUM_BITS'(b_rr_reg) - SUM_BITS'(b_ii_reg);

    // The imaginary part doubles the cross product by shifting one bit less.
    assign d_nr_next = NEXT_BITS'(c_diff_reg >>> FRAC_BITS) + NEXT_BITS'(const_real_reg);
    assign d_ni_next = NEXT_BITS'(c_ri_reg >>> (FRAC_BITS - 1)) + NEXT_BITS'(const_imag_reg);

    assign comp_esc = (d_nr_reg > TWO_POS) || (d_nr_reg < TWO_NEG) ||
                      (d_ni_reg > TWO_POS) || (d_ni_reg < TWO_NEG);

    // The squares of stage B at pass i test the z produced by pass i-1, so a
    // magnitude escape seen there belongs to the previous iteration.
    always_comb begin
        finished   = 1'b1;
        fin_result = d_result_reg;
        if (d_done_reg) begin
            fin_result = d_result_reg;
        end else if (d_iter_reg != '0 && d_mag_esc_reg) begin
            fin_result = d_iter_reg - COUNT_BITS'(1);
        end else if (d_iter_reg == iter_limit_reg) begin
            fin_result = iter_limit_reg;
        end else if (comp_esc) begin
            fin_result = d_iter_reg;
        end else begin
            finished = 1'b0;
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign exit_now = d_valid_reg && finished && (d_tag_reg == out_seq_reg) && out_free;
    assign s_tready = !d_valid_reg || exit_now;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        a_valid_next  = 1'b0;
        a_done_next   = finished;
        a_tag_next    = d_tag_reg;
        a_iter_next   = d_iter_reg + COUNT_BITS'(1);
        a_result_next = fin_result;
        a_re_next     = WORD_BITS'(d_nr_reg);
        a_im_next     = WORD_BITS'(d_ni_reg);
        if (d_valid_reg && !exit_now) begin
            a_valid_next = 1'b1;
        end else if (accept) begin
            a_valid_next  = 1'b1;
            a_done_next   = 1'b0;
            a_tag_next    = in_seq_reg;
            a_iter_next   = '0;
            a_result_next = '0;
            a_re_next     = s_tdata[WORD_BITS-1:0];
            a_im_next     = s_tdata[2*WORD_BITS-1:WORD_BITS];
        end
    end

    always_comb begin
        in_seq_next  = accept ? in_seq_reg + TAG_BITS'(1) : in_seq_reg;
        out_seq_next = exit_now ? out_seq_reg + TAG_BITS'(1) : out_seq_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_count_next = m_count_reg;
        if (exit_now) begin
            m_valid_next = 1'b1;
            m_count_next = fin_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_count_reg);

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            const_real_reg <= '0;
            const_imag_reg <= '0;
            iter_limit_reg <= ITER_LIMIT_RESET;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            in_seq_reg     <= '0;
            out_seq_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_CONST_REAL: const_real_reg <= cfg_wdata;
                    CFG_CONST_IMAG: const_imag_reg <= cfg_wdata;
                    CFG_ITER_LIMIT: iter_limit_reg <= cfg_wdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            in_seq_reg  <= in_seq_next;
            out_seq_reg <= out_seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_done_reg    <= a_done_next;
        a_tag_reg     <= a_tag_next;
        a_iter_reg    <= a_iter_next;
        a_result_reg  <= a_result_next;
        a_re_reg      <= a_re_next;
        a_im_reg      <= a_im_next;

        b_done_reg    <= a_done_reg;
        b_tag_reg     <= a_tag_reg;
        b_iter_reg    <= a_iter_reg;
        b_result_reg  <= a_result_reg;
        b_rr_reg      <= b_rr_next;
        b_ii_reg      <= b_ii_next;
        b_ri_reg      <= b_ri_next;

        c_done_reg    <= b_done_reg;
        c_tag_reg     <= b_tag_reg;
        c_iter_reg    <= b_iter_reg;
        c_result_reg  <= b_result_reg;
        c_mag_esc_reg <= c_mag_esc_next;
        c_diff_reg    <= c_diff_next;
        c_ri_reg      <= b_ri_reg;

        d_done_reg    <= c_done_reg;
        d_tag_reg     <= c_tag_reg;
        d_iter_reg    <= c_iter_reg;
        d_result_reg  <= c_result_reg;
        d_mag_esc_reg <= c_mag_esc_reg;
        d_nr_reg      <= d_nr_next;
        d_ni_reg      <= d_ni_next;

        m_count_reg   <= m_count_next;
    end

    // ---------------------------------------------------------------- checks
    // Points sharing the ring never carry the same order tag.
    a_tags_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> (!b_valid_reg || a_tag_reg != b_tag_reg) &&
                        (!c_valid_reg || a_tag_reg != c_tag_reg) &&
                        (!d_valid_reg || a_tag_reg != d_tag_reg))
        else $error("two points in the ring share a tag");

    // An accepted point occupies the entry slot in the next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> a_valid_reg && !a_done_reg && a_iter_reg == '0)
        else $error("accepted point did not enter the ring");

    // A point still iterating never runs past the limit.
    a_iter_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_done_reg |-> a_iter_reg <= iter_limit_reg)
        else $error("iteration count beyond the limit");

    // A new result only appears when the decide stage held a point.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(d_valid_reg))
        else $error("result appeared without a finishing point");

endmodule
